// ----- hw/rtl/sccr_pkg.sv -----
// Shared constants, codes and controller/datapath interface types of the sector cache engine.
`default_nettype none
package sccr_pkg;

  localparam int SLOT_COUNT  = 64;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
  localparam int MAX_RESULTS = 64;
  localparam int EMIT_W      = $clog2(MAX_RESULTS);
  localparam int SECTOR_W    = 32;
  localparam int PIN_W       = 8;

  localparam int IN_FIELDS_W  = SECTOR_W + 1 + SLOT_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SLOT_W + 3 + SECTOR_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Operation codes carried in in_tuser
  localparam logic [1:0] FUNC_ACQUIRE = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH   = 2'd2;

  // Result status codes carried in out_tuser
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_PINNED  = 2'd1;
  localparam logic [1:0] STAT_BAD_REL = 2'd2;

  // Datapath actions on the slot record under the read register
  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_HIT     = 4'd1;
  localparam logic [3:0] OP_NEW     = 4'd2;
  localparam logic [3:0] OP_SWEEP   = 4'd3;
  localparam logic [3:0] OP_RELEASE = 4'd4;
  localparam logic [3:0] OP_FLUSH   = 4'd5;
  localparam logic [3:0] OP_PINNED  = 4'd6;
  localparam logic [3:0] OP_EMPTY   = 4'd7;

  typedef struct packed {
    logic [SECTOR_W-1:0] tag;
    logic                accessed;
    logic                dirty;
    logic [PIN_W-1:0]    pin;
  } sccr_rec_t;

  typedef struct packed {
    logic       load;
    logic       start_zero;
    logic       start_slot;
    logic       start_hand;
    logic       issue;
    logic       hold;
    logic [3:0] op;
  } sccr_cmd_t;

  typedef struct packed {
    logic rd_vld;
    logic match;
    logic victim;
    logic dirty;
    logic issue_more;
    logic full;
    logic none_unpinned;
    logic dirty_zero;
    logic flush_last;
    logic out_free;
  } sccr_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sccr_ctrl.sv -----
// Controller state machine: sequences lookup scan, fill, clock sweep, release and flush.
`default_nettype none
module sccr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic [1:0]         in_func,
  output logic                    in_tready,
  input  wire sccr_pkg::sccr_stat_t st,
  output sccr_pkg::sccr_cmd_t     cmd
);
  import sccr_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_ACQ_SCAN  = 3'd1;
  localparam logic [2:0] S_ACQ_MISS  = 3'd2;
  localparam logic [2:0] S_ACQ_SWEEP = 3'd3;
  localparam logic [2:0] S_REL_RD    = 3'd4;
  localparam logic [2:0] S_REL_ACT   = 3'd5;
  localparam logic [2:0] S_FL_SCAN   = 3'd6;
  localparam logic [2:0] S_FL_EMPTY  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op    = OP_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          case (in_func)
            FUNC_ACQUIRE: begin
              cmd.start_zero = 1'b1;
              state_nxt      = S_ACQ_SCAN;
            end
            FUNC_RELEASE: begin
              cmd.start_slot = 1'b1;
              state_nxt      = S_REL_RD;
            end
            FUNC_FLUSH: begin
              if (st.dirty_zero) begin
                state_nxt = S_FL_EMPTY;
              end else begin
                cmd.start_zero = 1'b1;
                state_nxt      = S_FL_SCAN;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ACQ_SCAN: begin
        if (st.match) begin
          if (st.out_free) begin
            cmd.op    = OP_HIT;
            state_nxt = S_IDLE;
          end else begin
            cmd.hold = 1'b1;
          end
        end else if (st.issue_more) begin
          cmd.issue = 1'b1;
        end else if (!st.rd_vld) begin
          state_nxt = S_ACQ_MISS;
        end
      end
      S_ACQ_MISS: begin
        if (!st.full) begin
          if (st.out_free) begin
            cmd.op    = OP_NEW;
            state_nxt = S_IDLE;
          end
        end else if (st.none_unpinned) begin
          if (st.out_free) begin
            cmd.op    = OP_PINNED;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.start_hand = 1'b1;
          state_nxt      = S_ACQ_SWEEP;
        end
      end
      S_ACQ_SWEEP: begin
        if (st.victim) begin
          if (st.out_free) begin
            cmd.op    = OP_SWEEP;
            state_nxt = S_IDLE;
          end else begin
            cmd.hold = 1'b1;
          end
        end else begin
          cmd.issue = 1'b1;
          if (st.rd_vld) begin
            cmd.op = OP_SWEEP;
          end
        end
      end
      S_REL_RD: begin
        cmd.issue = 1'b1;
        state_nxt = S_REL_ACT;
      end
      S_REL_ACT: begin
        if (st.out_free) begin
          cmd.op    = OP_RELEASE;
          state_nxt = S_IDLE;
        end else begin
          cmd.hold = 1'b1;
        end
      end
      S_FL_SCAN: begin
        if (st.dirty) begin
          if (st.out_free) begin
            cmd.op = OP_FLUSH;
            if (st.flush_last) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.issue = st.issue_more;
            end
          end else begin
            cmd.hold = 1'b1;
          end
        end else begin
          cmd.issue = st.issue_more;
        end
      end
      S_FL_EMPTY: begin
        if (st.out_free) begin
          cmd.op    = OP_EMPTY;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sccr_datapath.sv -----
// Datapath: slot record memory, scan pointer, occupancy counters and result register.
`default_nettype none
module sccr_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire sccr_pkg::sccr_cmd_t                cmd,
  output sccr_pkg::sccr_stat_t                    st,
  input  wire logic [sccr_pkg::SECTOR_W-1:0]      in_sector,
  input  wire logic                               in_mark_dirty,
  input  wire logic [sccr_pkg::SLOT_W-1:0]        in_slot,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [sccr_pkg::SLOT_W-1:0]             out_slot_index,
  output logic                                    out_hit,
  output logic                                    out_fill_needed,
  output logic                                    out_writeback_valid,
  output logic [sccr_pkg::SECTOR_W-1:0]           out_writeback_sector,
  output logic [1:0]                              out_status,
  output logic                                    out_last
);
  import sccr_pkg::*;

  sccr_rec_t mem [SLOT_COUNT];

  // Request latched at accept
  logic [SECTOR_W-1:0] req_sector_r;
  logic                req_dirty_r;
  logic [SLOT_W-1:0]   req_slot_r;

  // Read pipeline
  logic [SLOT_W-1:0] rd_idx_r;
  logic [SLOT_W-1:0] rd_slot_r;
  sccr_rec_t         rd_data_r;
  logic              rd_vld_r;
  logic [CNT_W-1:0]  issue_cnt_r;

  // Policy state
  logic [CNT_W-1:0]  in_use_r,   in_use_nxt;
  logic [SLOT_W-1:0] hand_r,     hand_nxt;
  logic [CNT_W-1:0]  unpinned_r, unpinned_nxt;
  logic [CNT_W-1:0]  dirty_cnt_r, dirty_cnt_nxt;
  logic [EMIT_W-1:0] emit_cnt_r, emit_cnt_nxt;

  // Result register
  logic                out_valid_r;
  logic [SLOT_W-1:0]   res_slot_r,   res_slot_nxt;
  logic                res_hit_r,    res_hit_nxt;
  logic                res_fill_r,   res_fill_nxt;
  logic                res_wbv_r,    res_wbv_nxt;
  logic [SECTOR_W-1:0] res_wbs_r,    res_wbs_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic                res_last_r,   res_last_nxt;

  logic              we;
  logic [SLOT_W-1:0] waddr;
  sccr_rec_t         wdata;
  logic              emit;
  logic              bad_rel;
  logic              out_free;
  logic [SLOT_W-1:0] rd_idx_inc;
  logic [SLOT_W-1:0] rd_slot_inc;

  assign out_free    = !out_valid_r || out_ready;
  assign bad_rel     = {1'b0, req_slot_r} >= in_use_r;
  assign rd_idx_inc  = (rd_idx_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : rd_idx_r + 1'b1;
  assign rd_slot_inc = (rd_slot_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : rd_slot_r + 1'b1;

  always_comb begin
    st.rd_vld        = rd_vld_r;
    st.match         = rd_vld_r && (rd_data_r.tag == req_sector_r);
    st.victim        = rd_vld_r && (rd_data_r.pin == '0) && !rd_data_r.accessed;
    st.dirty         = rd_vld_r && rd_data_r.dirty;
    st.issue_more    = issue_cnt_r < in_use_r;
    st.full          = in_use_r == CNT_W'(SLOT_COUNT);
    st.none_unpinned = unpinned_r == '0;
    st.dirty_zero    = dirty_cnt_r == '0;
    st.flush_last    = (dirty_cnt_r == CNT_W'(1)) || (emit_cnt_r == EMIT_W'(MAX_RESULTS - 1));
    st.out_free      = out_free;
  end

  // Action on the record under the read register
  always_comb begin
    we             = 1'b0;
    waddr          = rd_slot_r;
    wdata          = rd_data_r;
    emit           = 1'b0;
    in_use_nxt     = in_use_r;
    hand_nxt       = hand_r;
    unpinned_nxt   = unpinned_r;
    dirty_cnt_nxt  = dirty_cnt_r;
    emit_cnt_nxt   = emit_cnt_r;
    res_slot_nxt   = '0;
    res_hit_nxt    = 1'b0;
    res_fill_nxt   = 1'b0;
    res_wbv_nxt    = 1'b0;
    res_wbs_nxt    = '0;
    res_status_nxt = STAT_OK;
    res_last_nxt   = 1'b1;
    unique case (cmd.op)
      OP_NONE: ;
      OP_HIT: begin
        we             = 1'b1;
        wdata.accessed = 1'b1;
        wdata.dirty    = rd_data_r.dirty | req_dirty_r;
        if (rd_data_r.pin != {PIN_W{1'b1}}) begin
          wdata.pin = rd_data_r.pin + 1'b1;
        end
        if (rd_data_r.pin == '0) begin
          unpinned_nxt = unpinned_r - 1'b1;
        end
        if (!rd_data_r.dirty && req_dirty_r) begin
          dirty_cnt_nxt = dirty_cnt_r + 1'b1;
        end
        emit         = 1'b1;
        res_slot_nxt = rd_slot_r;
        res_hit_nxt  = 1'b1;
      end
      OP_NEW: begin
        we             = 1'b1;
        waddr          = in_use_r[SLOT_W-1:0];
        wdata.tag      = req_sector_r;
        wdata.accessed = 1'b1;
        wdata.dirty    = req_dirty_r;
        wdata.pin      = PIN_W'(1);
        in_use_nxt     = in_use_r + 1'b1;
        dirty_cnt_nxt  = dirty_cnt_r + CNT_W'(req_dirty_r);
        emit           = 1'b1;
        res_slot_nxt   = in_use_r[SLOT_W-1:0];
        res_fill_nxt   = 1'b1;
      end
      OP_SWEEP: begin
        if (rd_data_r.pin == '0) begin
          we = 1'b1;
          if (rd_data_r.accessed) begin
            // second chance: clear and move on
            wdata.accessed = 1'b0;
          end else begin
            wdata.tag      = req_sector_r;
            wdata.accessed = 1'b1;
            wdata.dirty    = req_dirty_r;
            wdata.pin      = PIN_W'(1);
            hand_nxt       = rd_slot_inc;
            unpinned_nxt   = unpinned_r - 1'b1;
            dirty_cnt_nxt  = dirty_cnt_r - CNT_W'(rd_data_r.dirty) + CNT_W'(req_dirty_r);
            emit           = 1'b1;
            res_slot_nxt   = rd_slot_r;
            res_fill_nxt   = 1'b1;
            res_wbv_nxt    = rd_data_r.dirty;
            res_wbs_nxt    = rd_data_r.dirty ? rd_data_r.tag : '0;
          end
        end
      end
      OP_RELEASE: begin
        emit         = 1'b1;
        res_slot_nxt = req_slot_r;
        if (bad_rel) begin
          res_status_nxt = STAT_BAD_REL;
        end else begin
          we = 1'b1;
          if (rd_data_r.pin != '0) begin
            wdata.pin = rd_data_r.pin - 1'b1;
          end
          if (rd_data_r.pin == PIN_W'(1)) begin
            unpinned_nxt = unpinned_r + 1'b1;
          end
        end
      end
      OP_FLUSH: begin
        we            = 1'b1;
        wdata.dirty   = 1'b0;
        dirty_cnt_nxt = dirty_cnt_r - 1'b1;
        emit_cnt_nxt  = emit_cnt_r + 1'b1;
        emit          = 1'b1;
        res_slot_nxt  = rd_slot_r;
        res_wbv_nxt   = 1'b1;
        res_wbs_nxt   = rd_data_r.tag;
        res_last_nxt  = st.flush_last;
      end
      OP_PINNED: begin
        emit           = 1'b1;
        res_status_nxt = STAT_PINNED;
      end
      OP_EMPTY: begin
        emit = 1'b1;
      end
      default: ;
    endcase
    if (cmd.load) begin
      emit_cnt_nxt = '0;
    end
  end

  // Slot record memory, one write and one registered read per cycle; the read waits while cmd.hold is set
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.issue && !cmd.hold) begin
      rd_data_r <= mem[rd_idx_r];
      rd_slot_r <= rd_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_sector_r <= in_sector;
      req_dirty_r  <= in_mark_dirty;
      req_slot_r   <= in_slot;
    end
    if (emit) begin
      res_slot_r   <= res_slot_nxt;
      res_hit_r    <= res_hit_nxt;
      res_fill_r   <= res_fill_nxt;
      res_wbv_r    <= res_wbv_nxt;
      res_wbs_r    <= res_wbs_nxt;
      res_status_r <= res_status_nxt;
      res_last_r   <= res_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      rd_vld_r    <= 1'b0;
      issue_cnt_r <= '0;
      in_use_r    <= '0;
      hand_r      <= '0;
      unpinned_r  <= '0;
      dirty_cnt_r <= '0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_use_r    <= in_use_nxt;
      hand_r      <= hand_nxt;
      unpinned_r  <= unpinned_nxt;
      dirty_cnt_r <= dirty_cnt_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      if (cmd.start_zero) begin
        rd_idx_r    <= '0;
        issue_cnt_r <= '0;
        rd_vld_r    <= 1'b0;
      end else if (cmd.start_slot) begin
        rd_idx_r    <= in_slot;
        issue_cnt_r <= '0;
        rd_vld_r    <= 1'b0;
      end else if (cmd.start_hand) begin
        rd_idx_r    <= hand_r;
        issue_cnt_r <= '0;
        rd_vld_r    <= 1'b0;
      end else if (cmd.hold) begin
        rd_vld_r <= rd_vld_r;
      end else if (cmd.issue) begin
        rd_idx_r    <= rd_idx_inc;
        issue_cnt_r <= issue_cnt_r + 1'b1;
        rd_vld_r    <= 1'b1;
      end else begin
        rd_vld_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_slot_index       = res_slot_r;
  assign out_hit              = res_hit_r;
  assign out_fill_needed      = res_fill_r;
  assign out_writeback_valid  = res_wbv_r;
  assign out_writeback_sector = res_wbs_r;
  assign out_status           = res_status_r;
  assign out_last             = res_last_r;

endmodule
`default_nettype wire

// ----- hw/rtl/sector_cache_clock_replacement_core.sv -----
// Top level of the sector cache tag and clock-replacement policy engine.
// Usage: one item on the in_ channel is one request, selected by in_tuser:
//   acquire a sector, release a slot's pin, or flush all dirty slots.
// Results leave on the out_ channel; out_tlast marks the final result of a request.
// Acquire and release give one result; flush gives one result per dirty slot
// (ascending slot order), or a single empty result when nothing is dirty.
// Requests are handled one at a time; in_tready is high only while the
// controller waits for a request, and an unknown operation is dropped.
// The time to a result is set by the slot record memory, which gives one read
// per cycle unless a stalled result holds the scan; the next item can be taken
// in the cycle after the result is loaded. Slots read per request:
//   acquire hit on slot i: slots 0 to i; acquire miss with a free slot:
//   every filled slot, none on an empty cache; acquire on a full cache with
//   every slot pinned: every slot; clock sweep: every slot, then slots from
//   the hand, at most two passes over 64 slots; release: the one slot; flush:
//   slots up to the last dirty slot, or none when nothing is dirty.
// Reset empties the cache: occupancy, clock hand, pin and dirty counters go
// to zero; no clearing pass runs, and only a release of an unfilled slot reads
// past the filled slots of the tag memory. When the receiver stalls, the result
// register holds and the scan freezes on the next slot with a result to give.
`default_nettype none
module sector_cache_clock_replacement_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // sector[31:0], mark_dirty[32], slot[38:33], zero pad
  input  wire logic [sccr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func[1:0]
  input  wire logic [1:0]                       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // slot_index[5:0], hit[6], fill_needed[7], writeback_valid[8],
  // writeback_sector[40:9], zero pad
  output logic [sccr_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // status[1:0]
  output logic [1:0]                            out_tuser,
  output logic                                  out_tlast
);
  import sccr_pkg::*;

  sccr_cmd_t           cmd;
  sccr_stat_t          st;
  logic [SLOT_W-1:0]   res_slot;
  logic                res_hit;
  logic                res_fill;
  logic                res_wbv;
  logic [SECTOR_W-1:0] res_wbs;

  sccr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  sccr_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .st                   (st),
    .in_sector            (in_tdata[SECTOR_W-1:0]),
    .in_mark_dirty        (in_tdata[SECTOR_W]),
    .in_slot              (in_tdata[SECTOR_W+SLOT_W:SECTOR_W+1]),
    .out_valid            (out_tvalid),
    .out_ready            (out_tready),
    .out_slot_index       (res_slot),
    .out_hit              (res_hit),
    .out_fill_needed      (res_fill),
    .out_writeback_valid  (res_wbv),
    .out_writeback_sector (res_wbs),
    .out_status           (out_tuser),
    .out_last             (out_tlast)
  );

  // Pack result fields, lowest field first
  assign out_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                      res_wbs, res_wbv, res_fill, res_hit, res_slot};

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking stream testbench for the sector cache clock-replacement core.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sccr_pkg::*;

  // func 3 is not an operation; the core drops it without a result
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int HOLD_OFF_CYCLES = 400;   // long receiver hold-off, fills the core
  localparam int STALL_LIMIT     = 4000;  // cycles with no item moving on either side
  localparam int DRAIN_CYCLES    = 400;   // longer than the slowest clock sweep
  localparam int RANDOM_ITEMS    = 60;
  localparam int REPORT_MAX      = 10;
  localparam int POOL_SIZE       = 80;    // more sectors than slots, so misses hit a full cache
  localparam int BURST_ACQUIRES  = 258;   // enough hits to push a pin count past 255

  // One result item as the core presents it
  typedef struct packed {
    logic [SLOT_W-1:0]   slot_index;
    logic                hit;
    logic                fill_needed;
    logic                writeback_valid;
    logic [SECTOR_W-1:0] writeback_sector;
    logic [1:0]          status;
    logic                last;
  } grant_t;

  // One row of the directed table; n_fixed is -1 for predicted rows,
  // 0 where no result may come, 1 where the result is typed in
  typedef struct {
    logic [1:0]          op;
    logic [SECTOR_W-1:0] sector;
    logic                dirty;
    logic [SLOT_W-1:0]   slot;
    int                  n_fixed;
    grant_t              fixed;
  } request_row_t;

  localparam grant_t NO_GRANT = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = FUNC_ACQUIRE;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  sector_cache_clock_replacement_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted cache state, updated at the edge where each request item is taken
  logic [SECTOR_W-1:0] slot_tag      [SLOT_COUNT];
  bit                  slot_accessed [SLOT_COUNT];
  bit                  slot_dirty    [SLOT_COUNT];
  logic [PIN_W-1:0]    slot_pins     [SLOT_COUNT];
  int unsigned         fill_count;
  int unsigned         hand_pos;

  grant_t pending_grants[$];   // results still owed by the core, oldest first
  int     pinned_slots[$];     // slots this bench holds a pin on, for well-formed releases
  logic [SECTOR_W-1:0] sector_pool[POOL_SIZE];

  int n_fail = 0;
  int items_accepted = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off_request = 1'b0;

  // Take a slot for a new sector: pinned once, accessed, dirty as requested
  function automatic void claim_slot(int unsigned s, logic [SECTOR_W-1:0] sector, logic dirty);
    slot_tag[s] = sector;
    slot_accessed[s] = 1'b1;
    slot_dirty[s] = dirty;
    slot_pins[s] = PIN_W'(1);
  endfunction

  // Work out the results of one request and advance the predicted state
  function automatic void cache_policy_step(input logic [1:0] op,
      input logic [SECTOR_W-1:0] sector, input logic dirty,
      input logic [SLOT_W-1:0] slot, ref grant_t res[$]);
    int unsigned s;
    bit any_unpinned;
    grant_t g;
    res.delete();
    g = NO_GRANT;
    g.last = 1'b1;
    case (op)
      FUNC_ACQUIRE: begin
        // hit: only filled slots hold valid tags
        for (int unsigned i = 0; i < fill_count; i++) begin
          if (slot_tag[i] == sector) begin
            slot_accessed[i] = 1'b1;
            slot_dirty[i] = slot_dirty[i] | dirty;
            if (slot_pins[i] != 8'hFF) slot_pins[i] = slot_pins[i] + 1'b1;
            g.slot_index = i[SLOT_W-1:0];
            g.hit = 1'b1;
            res.push_back(g);
            return;
          end
        end
        // miss with a never-used slot left
        if (fill_count < SLOT_COUNT) begin
          s = fill_count;
          fill_count++;
          claim_slot(s, sector, dirty);
          g.slot_index = s[SLOT_W-1:0];
          g.fill_needed = 1'b1;
          res.push_back(g);
          return;
        end
        any_unpinned = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
          if (slot_pins[i] == 0) any_unpinned = 1'b1;
        if (any_unpinned) begin
          // second-chance sweep from the persistent hand
          s = hand_pos;
          repeat (2 * SLOT_COUNT + 1) begin
            if (slot_pins[s] == 0) begin
              if (slot_accessed[s]) begin
                slot_accessed[s] = 1'b0;
              end else begin
                g.slot_index = s[SLOT_W-1:0];
                g.fill_needed = 1'b1;
                g.writeback_valid = slot_dirty[s];
                g.writeback_sector = slot_dirty[s] ? slot_tag[s] : '0;
                claim_slot(s, sector, dirty);
                hand_pos = (s + 1) % SLOT_COUNT;
                res.push_back(g);
                return;
              end
            end
            s = (s + 1) % SLOT_COUNT;
          end
        end
        // every slot pinned: no victim, nothing changes
        g.status = STAT_PINNED;
        res.push_back(g);
      end
      FUNC_RELEASE: begin
        g.slot_index = slot;
        if (slot >= fill_count) begin
          g.status = STAT_BAD_REL;
        end else if (slot_pins[slot] != 0) begin
          slot_pins[slot] = slot_pins[slot] - 1'b1;
        end
        res.push_back(g);
      end
      FUNC_FLUSH: begin
        for (int unsigned i = 0; i < fill_count; i++) begin
          if (slot_dirty[i]) begin
            slot_dirty[i] = 1'b0;
            g = NO_GRANT;
            g.slot_index = i[SLOT_W-1:0];
            g.writeback_valid = 1'b1;
            g.writeback_sector = slot_tag[i];
            res.push_back(g);
          end
        end
        if (res.size() == 0) begin
          g = NO_GRANT;
          g.last = 1'b1;
          res.push_back(g);
        end else begin
          res[res.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // A miss now would find no victim
  function automatic bit no_victim_left();
    if (fill_count < SLOT_COUNT) return 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++)
      if (slot_pins[i] == 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [SECTOR_W-1:0] pick_sector();
    if ($urandom_range(99) < 75) return sector_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Offer one request item, hold it until taken, then predict its results.
  // granted returns the slot of a successful acquire, else -1.
  task automatic issue_request(input logic [1:0] op, input logic [SECTOR_W-1:0] sector,
      input logic dirty, input logic [SLOT_W-1:0] slot, input int n_fixed,
      input grant_t fixed, output int granted);
    logic [IN_TDATA_W-1:0] word;
    grant_t predicted[$];
    word = '0;
    word[SECTOR_W-1:0] = sector;
    word[SECTOR_W] = dirty;
    word[SECTOR_W+SLOT_W:SECTOR_W+1] = slot;
    in_tvalid <= 1'b1;
    in_tdata <= word;
    in_tuser <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    cache_policy_step(op, sector, dirty, slot, predicted);
    granted = -1;
    if (op == FUNC_ACQUIRE && predicted[0].status == STAT_OK)
      granted = int'(predicted[0].slot_index);
    if (n_fixed < 0) begin
      foreach (predicted[i]) pending_grants.push_back(predicted[i]);
    end else if (n_fixed == 1) begin
      pending_grants.push_back(fixed);
    end
    if (op != FUNC_UNUSED) items_accepted++;
    // sender idle gap; valid stays up when there is none
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
  endtask

  // Acquire and remember the pin for a later release
  task automatic acquire_and_hold(input logic [SECTOR_W-1:0] sector, input logic dirty);
    int granted;
    issue_request(FUNC_ACQUIRE, sector, dirty, SLOT_W'($urandom_range(SLOT_COUNT - 1)), -1,
                  NO_GRANT, granted);
    if (granted >= 0) pinned_slots.push_back(granted);
  endtask

  // Drop one held pin; with none held, release an arbitrary slot
  task automatic release_one();
    int granted;
    int k;
    logic [SLOT_W-1:0] target;
    if (pinned_slots.size() > 0) begin
      k = $urandom_range(pinned_slots.size() - 1);
      target = SLOT_W'(pinned_slots[k]);
      pinned_slots.delete(k);
    end else begin
      target = SLOT_W'($urandom_range(SLOT_COUNT - 1));
    end
    issue_request(FUNC_RELEASE, $urandom, 1'($urandom_range(1)), target, -1, NO_GRANT,
                  granted);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result item with the oldest prediction
  always @(posedge clk) begin : result_check
    grant_t got;
    grant_t want;
    bit bad;
    if (rst_n && out_tvalid && out_tready) begin
      got.slot_index       = out_tdata[SLOT_W-1:0];
      got.hit              = out_tdata[SLOT_W];
      got.fill_needed      = out_tdata[SLOT_W+1];
      got.writeback_valid  = out_tdata[SLOT_W+2];
      got.writeback_sector = out_tdata[SLOT_W+3+SECTOR_W-1:SLOT_W+3];
      got.status           = out_tuser;
      got.last             = out_tlast;
      if (pending_grants.size() == 0) begin
        n_fail++;
        if (n_fail <= REPORT_MAX)
          $display("%0t: unexpected result: slot %0d status %0d last %0b",
                   $realtime, got.slot_index, got.status, got.last);
      end else begin
        want = pending_grants.pop_front();
        bad = (got.slot_index !== want.slot_index) || (got.hit !== want.hit) ||
              (got.fill_needed !== want.fill_needed) ||
              (got.writeback_valid !== want.writeback_valid) ||
              (got.writeback_sector !== want.writeback_sector) ||
              (got.status !== want.status) || (got.last !== want.last);
        if (bad) begin
          n_fail++;
          if (n_fail <= REPORT_MAX)
            $display("%0t: mismatch slot/hit/fill/wb/sector/status/last", $realtime,
                     " exp %0d %0b %0b %0b %h %0d %0b",
                     want.slot_index, want.hit, want.fill_needed,
                     want.writeback_valid, want.writeback_sector, want.status, want.last,
                     " got %0d %0b %0b %0b %h %0d %0b",
                     got.slot_index, got.hit, got.fill_needed, got.writeback_valid,
                     got.writeback_sector, got.status, got.last);
        end
      end
    end
  end

  // Watchdog: end the run if no item moves on either side for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    request_row_t directed_rows[21];
    int granted;
    int burst_slot;
    logic [SECTOR_W-1:0] burst_sector;
    int round_goal;
    int kind;
    int n;
    bit hoard_done;
    bit pressure_done;

    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_accessed[i] = 1'b0;
      slot_dirty[i] = 1'b0;
      slot_pins[i] = '0;
    end
    fill_count = 0;
    hand_pos = 0;

    // Sector pool: field extremes first, the rest random
    sector_pool[0] = 32'h0000_0000;
    sector_pool[1] = 32'hFFFF_FFFF;
    sector_pool[2] = 32'h8000_0000;
    sector_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) sector_pool[i] = $urandom;

    // Directed requests; typed results only where they follow from an empty cache
    directed_rows = '{
      // release at the bottom and at the top of the slot range on an empty cache
      '{FUNC_RELEASE, 32'h0000_0000, 1'b0, 6'd0,  1,
        '{6'd0,  1'b0, 1'b0, 1'b0, 32'h0, STAT_BAD_REL, 1'b1}},
      '{FUNC_RELEASE, 32'hFFFF_FFFF, 1'b1, 6'd63, 1,
        '{6'd63, 1'b0, 1'b0, 1'b0, 32'h0, STAT_BAD_REL, 1'b1}},
      // flush with nothing dirty gives one empty result
      '{FUNC_FLUSH,   32'hA5A5_A5A5, 1'b1, 6'd21, 1,
        '{6'd0,  1'b0, 1'b0, 1'b0, 32'h0, STAT_OK,      1'b1}},
      // unknown operation: dropped, no result
      '{FUNC_UNUSED,  32'h5A5A_5A5A, 1'b0, 6'd42, 0, NO_GRANT},
      // first fills take slots in order
      '{FUNC_ACQUIRE, 32'h0000_0000, 1'b0, 6'd0,  1,
        '{6'd0,  1'b0, 1'b1, 1'b0, 32'h0, STAT_OK,      1'b1}},
      '{FUNC_ACQUIRE, 32'hFFFF_FFFF, 1'b1, 6'd63, 1,
        '{6'd1,  1'b0, 1'b1, 1'b0, 32'h0, STAT_OK,      1'b1}},
      // hits: mark dirty on a clean slot, clean request on a dirty one
      '{FUNC_ACQUIRE, 32'h0000_0000, 1'b1, 6'd0,  -1, NO_GRANT},
      '{FUNC_ACQUIRE, 32'hFFFF_FFFF, 1'b0, 6'd0,  -1, NO_GRANT},
      // release down to zero, then once more on an unpinned slot
      '{FUNC_RELEASE, 32'h0000_0000, 1'b0, 6'd1,  -1, NO_GRANT},
      '{FUNC_RELEASE, 32'h0000_0000, 1'b0, 6'd1,  -1, NO_GRANT},
      '{FUNC_RELEASE, 32'h0000_0000, 1'b0, 6'd1,  -1, NO_GRANT},
      // release just past the filled slots
      '{FUNC_RELEASE, 32'h0000_0000, 1'b0, 6'd2,  -1, NO_GRANT},
      // flush reports both dirty slots, then nothing
      '{FUNC_FLUSH,   32'h0000_0000, 1'b0, 6'd0,  -1, NO_GRANT},
      '{FUNC_FLUSH,   32'h0000_0000, 1'b0, 6'd0,  -1, NO_GRANT},
      '{FUNC_ACQUIRE, 32'h8000_0000, 1'b1, 6'd0,  -1, NO_GRANT},
      '{FUNC_ACQUIRE, 32'h7FFF_FFFF, 1'b0, 6'd0,  -1, NO_GRANT},
      '{FUNC_UNUSED,  32'hFFFF_FFFF, 1'b1, 6'd63, 0, NO_GRANT},
      '{FUNC_ACQUIRE, 32'h0000_0001, 1'b1, 6'd0,  -1, NO_GRANT},
      '{FUNC_RELEASE, 32'h0000_0000, 1'b0, 6'd0,  -1, NO_GRANT},
      '{FUNC_FLUSH,   32'h0000_0000, 1'b0, 6'd0,  -1, NO_GRANT},
      '{FUNC_ACQUIRE, 32'h0000_0000, 1'b0, 6'd0,  -1, NO_GRANT}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 10;
    recv_stall_pct = 10;
    foreach (directed_rows[i])
      issue_request(directed_rows[i].op, directed_rows[i].sector, directed_rows[i].dirty,
                    directed_rows[i].slot, directed_rows[i].n_fixed, directed_rows[i].fixed,
                    granted);

    // Pin saturation: hammer one sector past 255 pins, then drop a few.
    // A wrapping counter would leave this slot unpinned and a later sweep would take it.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    burst_slot = -1;
    burst_sector = 32'hD15C_0000 | $urandom_range(16'hFFFF);
    for (int i = 0; i < BURST_ACQUIRES; i++) begin
      issue_request(FUNC_ACQUIRE, burst_sector, 1'($urandom_range(1)),
                    SLOT_W'($urandom_range(SLOT_COUNT - 1)), -1, NO_GRANT, granted);
      if (i == 0) burst_slot = granted;
      if (i == 0 && burst_slot < 0) break;
    end
    // keep hitting the same tag from the random part
    if (burst_slot >= 0) sector_pool[4] = burst_sector;
    if (burst_slot >= 0)
      repeat (3)
        issue_request(FUNC_RELEASE, $urandom, 1'b0, SLOT_W'(burst_slot), -1, NO_GRANT,
                      granted);

    // Random rounds: no idling, sender idle, receiver stalling, both lightly
    pressure_done = 1'b0;
    for (int round = 0; round < 4; round++) begin
      case (round)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      round_goal = items_accepted + RANDOM_ITEMS / 4;
      hoard_done = (round != 0);
      while (items_accepted < round_goal) begin
        // hold the receiver off while requests keep coming
        if (round == 0 && !pressure_done && items_accepted >= round_goal - 70) begin
          hold_off_request = 1'b1;
          pressure_done = 1'b1;
        end
        // pin every slot so misses find no victim, then give some pins back
        if (!hoard_done && items_accepted >= round_goal - 50) begin
          hoard_done = 1'b1;
          while (!no_victim_left()) acquire_and_hold($urandom, 1'($urandom_range(1)));
          repeat (3) acquire_and_hold($urandom, 1'($urandom_range(1)));
          acquire_and_hold(slot_tag[0], 1'b1);
          repeat ($urandom_range(8, 20)) release_one();
        end
        kind = $urandom_range(99);
        if (kind < 45) begin
          // working set: a few acquires, then some held pins dropped
          n = $urandom_range(1, 6);
          repeat (n) acquire_and_hold(pick_sector(), 1'($urandom_range(1)));
          repeat ($urandom_range(n)) release_one();
        end else if (kind < 65) begin
          repeat ($urandom_range(1, 3)) release_one();
        end else if (kind < 75) begin
          issue_request(FUNC_FLUSH, $urandom, 1'($urandom_range(1)),
                        SLOT_W'($urandom_range(SLOT_COUNT - 1)), -1, NO_GRANT, granted);
        end else begin
          // noise: any operation, any field values
          issue_request(2'($urandom_range(3)), $urandom, 1'($urandom_range(1)),
                        SLOT_W'($urandom_range(SLOT_COUNT - 1)), -1, NO_GRANT, granted);
          if (granted >= 0) pinned_slots.push_back(granted);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0 && pending_grants.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
